[sv/pip_pkg.sv]
package pip_pkg;

    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int M_DATA_W = 8;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
    } edge_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic crossed;
    } edge_res_t;

endpackage

[sv/pip_edge_unit.sv]
module pip_edge_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pip_pkg::edge_ctl_t            ctl,
    input  logic signed [COORD_WIDTH-1:0] xi,
    input  logic signed [COORD_WIDTH-1:0] yi,
    input  logic signed [COORD_WIDTH-1:0] xn,
    input  logic signed [COORD_WIDTH-1:0] yn,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output pip_pkg::edge_res_t            res
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int TW = PW + 1;

    logic signed [DW-1:0] dx0_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] ey_reg;
    logic signed [DW-1:0] ex_reg;
    logic                 cand1_reg;
    logic                 v1_reg;
    logic                 last1_reg;

    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic                 neg_reg;
    logic                 cand2_reg;
    logic                 v2_reg;
    logic                 last2_reg;

    logic signed [TW-1:0] t_sum;
    logic                 crossed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx0_reg   <= DW'(xi) - DW'(px);
        dy_reg    <= DW'(yn) - DW'(yi);
        ey_reg    <= DW'(py) - DW'(yi);
        ex_reg    <= DW'(xn) - DW'(xi);
        cand1_reg <= (yi > py) != (yn > py);
        last1_reg <= ctl.last;

        p1_reg    <= dx0_reg * dy_reg;
        p2_reg    <= ey_reg * ex_reg;
        neg_reg   <= dy_reg[DW-1];
        cand2_reg <= cand1_reg;
        last2_reg <= last1_reg;
    end

    assign t_sum   = TW'(p1_reg) + TW'(p2_reg);
    assign crossed = cand2_reg &&
                     (neg_reg ? t_sum[TW-1] : (!t_sum[TW-1] && (t_sum != '0)));

    assign res.valid   = v2_reg;
    assign res.last    = last2_reg;
    assign res.crossed = crossed;

endmodule

[sv/point_in_polygon_test.sv]
// Load beats write one vertex each, and the block takes one every cycle while no query runs.
// A query reads the vertex memory one vertex a cycle and runs each edge through a two-stage edge test.
// With n the vertex count capped at MAX_VERTICES, the result enters the output register from
// ST_DONE once the closing edge has left the edge test; a query with n of 0 goes straight there.
// The input is held until then, and ST_DONE waits while an earlier result is still untaken.
// Reset clears the control state and sets vertex_count to 3; vertex memory is not cleared.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pip_pkg::CNT_W-1:0]      cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vertex_index, coord_x, coord_y, zero pad
    input  logic [((pip_pkg::IDX_W + 2*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // action
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // inside_res, crossings
    output logic [pip_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = COORD_WIDTH;
    localparam int XLO = pip_pkg::IDX_W;
    localparam int YLO = pip_pkg::IDX_W + COORD_WIDTH;
    localparam int NW  = pip_pkg::CNT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DONE} state_t;

    state_t state_reg;

    logic [NW-1:0]          vertex_count_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          n_eff;
    logic [NW-1:0]          rd_ptr_reg;
    logic [NW-1:0]          cnt_reg;
    logic signed [CW-1:0]   px_reg;
    logic signed [CW-1:0]   py_reg;
    logic                   m_tvalid_reg;
    logic [pip_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [2*CW-1:0]        vmem [MAX_VERTICES];
    logic [2*CW-1:0]        rdata_reg;
    logic [2*CW-1:0]        prev_reg;
    logic [2*CW-1:0]        first_reg;
    logic                   rvalid_reg;
    logic                   rfirst_reg;
    logic                   rlast_reg;
    logic                   wrap_pend_reg;

    logic                   s_accept;
    logic [pip_pkg::IDX_W-1:0] in_idx;
    logic signed [CW-1:0]   in_x;
    logic signed [CW-1:0]   in_y;
    logic                   wr_en;
    logic                   rd_en;
    logic                   rd_last;
    logic [AW-1:0]          rd_addr;
    logic [2*CW-1:0]        next_vtx;

    pip_pkg::edge_ctl_t     edge_ctl;
    pip_pkg::edge_res_t     edge_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_idx   = s_tdata[pip_pkg::IDX_W-1:0];
    assign in_x     = signed'(s_tdata[XLO +: CW]);
    assign in_y     = signed'(s_tdata[YLO +: CW]);
    assign wr_en    = s_accept && (s_tuser[0] == pip_pkg::ACT_LOAD) &&
                      (32'(in_idx) < MAX_VERTICES);

    assign n_eff   = (32'(vertex_count_reg) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                             : vertex_count_reg;
    assign rd_en   = (state_reg == ST_WALK);
    assign rd_last = (rd_ptr_reg == (n_reg - NW'(1)));
    assign rd_addr = AW'(rd_ptr_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vmem[AW'(in_idx)] <= {in_y, in_x};
        end
        if (rd_en) begin
            rdata_reg <= vmem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= pip_pkg::VCOUNT_RESET;
        end else if (cfg_wr_en) begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvalid_reg    <= 1'b0;
            rfirst_reg    <= 1'b0;
            rlast_reg     <= 1'b0;
            wrap_pend_reg <= 1'b0;
        end else begin
            rvalid_reg    <= rd_en;
            rfirst_reg    <= rd_en && (rd_ptr_reg == '0);
            rlast_reg     <= rd_en && rd_last;
            wrap_pend_reg <= rvalid_reg && rlast_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rvalid_reg) begin
            prev_reg <= rdata_reg;
            if (rfirst_reg) begin
                first_reg <= rdata_reg;
            end
        end
    end

    assign next_vtx       = wrap_pend_reg ? first_reg : rdata_reg;
    assign edge_ctl.valid = wrap_pend_reg || (rvalid_reg && !rfirst_reg);
    assign edge_ctl.last  = wrap_pend_reg;

    pip_edge_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (edge_ctl),
        .xi      (signed'(prev_reg[CW-1:0])),
        .yi      (signed'(prev_reg[2*CW-1:CW])),
        .xn      (signed'(next_vtx[CW-1:0])),
        .yn      (signed'(next_vtx[2*CW-1:CW])),
        .px      (px_reg),
        .py      (py_reg),
        .res     (edge_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            n_reg        <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (edge_res.valid && edge_res.crossed) begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_tuser[0] == pip_pkg::ACT_QUERY)) begin
                        px_reg     <= in_x;
                        py_reg     <= in_y;
                        n_reg      <= n_eff;
                        cnt_reg    <= '0;
                        rd_ptr_reg <= '0;
                        state_reg  <= (n_eff == '0) ? ST_DONE : ST_WALK;
                    end
                end
                ST_WALK: begin
                    rd_ptr_reg <= rd_ptr_reg + NW'(1);
                    if (rd_last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (edge_res.valid && edge_res.last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {cnt_reg, cnt_reg[0]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_res_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_res.valid |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("Edge result outside of a query walk.");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && edge_res.valid && edge_res.last) |=> (state_reg == ST_DONE))
        else $error("Final edge did not close the query.");

    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rd_ptr_reg < n_reg))
        else $error("Vertex read beyond the vertex count.");

    a_wrap_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        wrap_pend_reg |-> !rvalid_reg)
        else $error("Closing edge overlaps a vertex read.");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_IDLE))
        else $error("Vertex write during a query.");

endmodule
